/* sv/cts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cts_pkg: shared definitions for the cosine series block
// Field widths, fixed-point formats, term limit and sequencer states.
// ----------------------------------------------------------------------------
package cts_pkg;

   localparam int MAX_TERMS   = 24;

   localparam int ANGLE_W     = 32;
   localparam int COS_W       = 32;
   localparam int TERMS_W     = 5;
   localparam int THR_W       = 31;
   localparam int THR_SHIFT   = 10;

   localparam int MAG_W       = 32;
   localparam int X2_W        = 63;
   localparam int FRAC_BITS   = 40;
   localparam int TERM_W      = 56;
   localparam int TERM_LO_W   = 28;
   localparam int TERM_HI_W   = TERM_W - TERM_LO_W;
   localparam int X2_LO_W     = 32;
   localparam int X2_HI_W     = X2_W - X2_LO_W;
   localparam int MUL_W       = 32;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int ACC_W       = TERM_W + X2_W;
   localparam int P_SHIFT     = 56;
   localparam int SUM_W       = 58;

   localparam int NUM_W       = 64;
   localparam int DIV_BITS    = 4;
   localparam int DIV_STEPS   = NUM_W / DIV_BITS;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam int CNT_W       = $clog2(MAX_TERMS + 1);
   localparam int DIV_W       = 2 * CNT_W + 2;

   localparam int MSTEP_W     = 3;
   localparam int MUL_STEPS   = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SQ_LOAD,
      ST_MUL,
      ST_DIV_LOAD,
      ST_DIV,
      ST_CHECK,
      ST_FINISH
   } state_type;

   function automatic logic [TERMS_W-1:0] to_terms(input logic [CNT_W-1:0] u);
      logic [CNT_W+TERMS_W-1:0] w;
      w = {{TERMS_W{1'b0}}, u};
      return w[TERMS_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* sv/cosine_taylor_series.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cosine_taylor_series: cosine of a Q4.28 angle by Maclaurin series
// Sums 1 - x^2/2! + x^4/4! - ... until a term falls to the accuracy
// threshold or the term limit is hit; result in Q2.30, saturated to +-1.
//
// Usage:
//  - req_*: one angle per transaction, accepted when req_valid && !req_stall.
//    req_stall is high from acceptance until the result has been moved to
//    the output register; the block works on one angle at a time.
//  - rsp_*: cosine, terms_used, limit_reached, held while rsp_stall is high.
//    A waiting result does not block acceptance of the next angle.
//  - csr_*: accuracy threshold write, always ready; write only when idle.
// Each term uses the shared 32x32 multiplier (four partial products of
//  term * x^2) and a radix-16 divider for the (2n-1)(2n) division, plus
//  load and check.
// Reset: synchronous; clears the sequencer and output valid, threshold = 1.
// ----------------------------------------------------------------------------
module cosine_taylor_series (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic signed [cts_pkg::ANGLE_W-1:0] req_angle,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic signed [cts_pkg::COS_W-1:0]   rsp_cosine,
   output      logic [cts_pkg::TERMS_W-1:0]        rsp_terms_used,
   output      logic                              rsp_limit_reached,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [cts_pkg::THR_W-1:0]          csr_accuracy_threshold
);
   import cts_pkg::*;

   localparam logic signed [SUM_W-1:0] SUM_ONE = SUM_W'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [SUM_W-1:0] SUM_RND = SUM_W'(64'sd1 <<< (THR_SHIFT - 1));
   localparam logic signed [COS_W-1:0] COS_POS = COS_W'(64'sd1 <<< 30);
   localparam logic signed [COS_W-1:0] COS_NEG = -COS_POS;

   state_type state_ff, state_in;

   logic [THR_W-1:0]           thr_ff;
   logic [MAG_W-1:0]           mag_ff;
   logic [X2_W-1:0]            x2_ff;
   logic [TERM_W-1:0]          term_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic [CNT_W-1:0]           used_ff;
   logic                       hit_ff;
   logic [MSTEP_W-1:0]         mstep_ff;
   logic [PROD_W-1:0]          prod_ff;
   logic [ACC_W-1:0]           acc_ff;
   logic [DIV_W-1:0]           d_ff;
   logic [NUM_W-1:0]           div_ff;
   logic [DIV_W-1:0]           rem_ff;
   logic [DIV_CNT_W-1:0]       dcnt_ff;

   logic                       rsp_valid_ff;
   logic signed [COS_W-1:0]    cos_ff;
   logic [TERMS_W-1:0]         terms_ff;
   logic                       limit_ff;

   logic                       req_take;
   logic                       out_load;
   logic                       div_last;
   logic                       term_small;
   logic                       last_term;

   logic [MUL_W-1:0]           mul_a, mul_b;
   logic [PROD_W-1:0]          mul_p;
   logic [ACC_W-1:0]           acc_add;
   logic [NUM_W-1:0]           limit;
   logic [DIV_W-1:0]           d_f1;
   logic [DIV_W-1:0]           d_f2;
   logic [DIV_W-1:0]           d_new;
   logic [NUM_W-1:0]           div_q;
   logic [DIV_W-1:0]           div_r;
   logic signed [SUM_W-1:0]    sum_rnd;
   logic signed [COS_W-1:0]    cos_val;
   logic [ANGLE_W-1:0]         angle_neg;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_take) state_in = ST_SQUARE;
         ST_SQUARE:   state_in = ST_SQ_LOAD;
         ST_SQ_LOAD:  state_in = ST_MUL;
         ST_MUL:      if (mstep_ff == MSTEP_W'(MUL_STEPS)) state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: state_in = ST_DIV;
         ST_DIV:      if (div_last) state_in = ST_CHECK;
         ST_CHECK:    if (term_small || last_term) state_in = ST_FINISH;
                      else state_in = ST_MUL;
         ST_FINISH:   if (out_load) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---------------- control outputs ----------------
   always_comb begin
      req_stall = 1'b1;
      out_load  = 1'b0;
      csr_ready = 1'b1;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_FINISH: out_load  = !rsp_valid_ff || !rsp_stall;
         default:   req_stall = 1'b1;
      endcase
   end

   assign req_take   = req_valid && !req_stall;
   assign div_last   = (dcnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign limit      = {{(NUM_W - THR_W - THR_SHIFT){1'b0}}, thr_ff, {THR_SHIFT{1'b0}}};
   assign term_small = (div_ff <= limit);
   assign last_term  = (used_ff == CNT_W'(MAX_TERMS - 1));
   assign angle_neg  = -req_angle;

   // shared multiplier: square of the angle, then partial products of term * x^2
   always_comb begin
      if (state_ff == ST_SQUARE) begin
         mul_a = mag_ff;
         mul_b = mag_ff;
      end else begin
         case (mstep_ff[1:0])
            2'd0: begin
               mul_a = MUL_W'(term_ff[TERM_LO_W-1:0]);
               mul_b = x2_ff[X2_LO_W-1:0];
            end
            2'd1: begin
               mul_a = MUL_W'(term_ff[TERM_LO_W-1:0]);
               mul_b = MUL_W'(x2_ff[X2_W-1:X2_LO_W]);
            end
            2'd2: begin
               mul_a = MUL_W'(term_ff[TERM_W-1:TERM_LO_W]);
               mul_b = x2_ff[X2_LO_W-1:0];
            end
            default: begin
               mul_a = MUL_W'(term_ff[TERM_W-1:TERM_LO_W]);
               mul_b = MUL_W'(x2_ff[X2_W-1:X2_LO_W]);
            end
         endcase
      end
      mul_p = mul_a * mul_b;
   end

   // product issued in the previous step, placed at its weight
   always_comb begin
      case (mstep_ff)
         MSTEP_W'(1): acc_add = ACC_W'(prod_ff);
         MSTEP_W'(2): acc_add = ACC_W'(prod_ff) << X2_LO_W;
         MSTEP_W'(3): acc_add = ACC_W'(prod_ff) << TERM_LO_W;
         default:     acc_add = ACC_W'(prod_ff) << (TERM_LO_W + X2_LO_W);
      endcase
   end

   // divisor (2n-1)(2n) with n = used + 1
   assign d_f1  = {{(DIV_W - CNT_W - 1){1'b0}}, used_ff, 1'b1};
   assign d_f2  = {{(DIV_W - CNT_W - 1){1'b0}}, used_ff + CNT_W'(1), 1'b0};
   assign d_new = d_f1 * d_f2;

   // radix-16 restoring division step
   always_comb begin
      logic [DIV_W:0] t;
      div_q = div_ff;
      div_r = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         t     = {div_r, div_q[NUM_W-1]};
         div_q = {div_q[NUM_W-2:0], 1'b0};
         if (t >= {1'b0, d_ff}) begin
            t        = t - {1'b0, d_ff};
            div_q[0] = 1'b1;
         end
         div_r = t[DIV_W-1:0];
      end
   end

   // round to Q2.30 and saturate
   always_comb begin
      sum_rnd = sum_ff + SUM_RND;
      if (sum_ff >= SUM_ONE)
         cos_val = COS_POS;
      else if (sum_ff <= -SUM_ONE)
         cos_val = COS_NEG;
      else
         cos_val = sum_rnd[COS_W+THR_SHIFT-1:THR_SHIFT];
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THR_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready)
            thr_ff <= csr_accuracy_threshold;
         if (out_load)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   // ---------------- datapath ----------------
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_take) begin
         mag_ff  <= req_angle[ANGLE_W-1] ? angle_neg : req_angle;
         term_ff <= TERM_W'(64'd1 << FRAC_BITS);
         sum_ff  <= SUM_ONE;
         used_ff <= '0;
         hit_ff  <= 1'b0;
      end
      if (state_ff == ST_SQUARE)
         prod_ff <= mul_p;
      if (state_ff == ST_SQ_LOAD) begin
         x2_ff    <= prod_ff[X2_W-1:0];
         mstep_ff <= '0;
      end
      if (state_ff == ST_MUL) begin
         mstep_ff <= mstep_ff + MSTEP_W'(1);
         prod_ff  <= mul_p;
         if (mstep_ff == '0) begin
            acc_ff <= '0;
            d_ff   <= d_new;
         end else begin
            acc_ff <= acc_ff + acc_add;
         end
      end
      if (state_ff == ST_DIV_LOAD) begin
         div_ff  <= NUM_W'(acc_ff[ACC_W-1:P_SHIFT]) + NUM_W'(d_ff >> 1);
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end
      if (state_ff == ST_DIV) begin
         div_ff  <= div_q;
         rem_ff  <= div_r;
         dcnt_ff <= dcnt_ff + DIV_CNT_W'(1);
      end
      if (state_ff == ST_CHECK && !term_small) begin
         term_ff  <= div_ff[TERM_W-1:0];
         mstep_ff <= '0;
         used_ff  <= used_ff + CNT_W'(1);
         if (used_ff[0] == 1'b0)
            sum_ff <= sum_ff - SUM_W'(div_ff[TERM_W-1:0]);
         else
            sum_ff <= sum_ff + SUM_W'(div_ff[TERM_W-1:0]);
         if (last_term)
            hit_ff <= 1'b1;
      end
      if (out_load) begin
         cos_ff   <= cos_val;
         terms_ff <= to_terms(used_ff);
         limit_ff <= hit_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cosine        = cos_ff;
   assign rsp_terms_used    = terms_ff;
   assign rsp_limit_reached = limit_ff;

endmodule
`default_nettype wire

/* bench/cosine_taylor_series_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cosine_taylor_series_tb: self-checking bench for the cosine series block
// Drives Q4.28 angles through the req_ channel and checks every rsp_
// transaction against a bit-exact series model kept in the bench. Runs a
// directed set, then random angles over several accuracy thresholds, with
// random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module cosine_taylor_series_tb;

   import cts_pkg::*;

   typedef struct packed {
      logic signed [COS_W-1:0] cosine;
      logic [TERMS_W-1:0]      terms_used;
      logic                    limit_reached;
   } cos_result_type;

   localparam longint                  ONE_Q40       = longint'(1) << FRAC_BITS;
   localparam logic signed [COS_W-1:0] COS_ONE       = 32'sh4000_0000;
   localparam logic signed [COS_W-1:0] COS_MINUS_ONE = 32'shC000_0000;
   localparam logic [THR_W-1:0]        THR_MAX       = 31'h7FFF_FFFF;
   localparam logic [THR_W-1:0]        THR_UNITY     = 31'h4000_0000;
   localparam int                      DRAIN_CYCLES  = 600;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [ANGLE_W-1:0] req_angle = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [COS_W-1:0]   rsp_cosine;
   logic [TERMS_W-1:0]        rsp_terms_used;
   logic                      rsp_limit_reached;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [THR_W-1:0]          csr_accuracy_threshold = '0;

   logic signed [ANGLE_W-1:0] angle_q[$];
   cos_result_type            cosine_q[$];
   logic [THR_W-1:0]          thr_model = 31'd1;
   int                        queued_total = 0;
   int                        accepted_total = 0;
   int                        fail_count = 0;
   bit                        no_idle = 1'b0;
   int                        gap_left = 0;
   int                        stall_left = 0;

   cosine_taylor_series dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_angle              (req_angle),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_cosine             (rsp_cosine),
      .rsp_terms_used         (rsp_terms_used),
      .rsp_limit_reached      (rsp_limit_reached),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_accuracy_threshold (csr_accuracy_threshold)
   );

   always #2 clock = ~clock;

   function automatic cos_result_type cosine_series(input logic signed [ANGLE_W-1:0] angle,
                                                    input logic [THR_W-1:0] thr);
      logic [32:0]    mag;
      logic [63:0]    x_sq;
      logic [63:0]    term;
      logic [63:0]    stop_at;
      logic [63:0]    d;
      logic [127:0]   prod;
      longint         sum;
      int             used;
      int             n;
      cos_result_type res;
      mag = angle[ANGLE_W-1] ? 33'h1_0000_0000 - {1'b0, angle} : {1'b0, angle};
      x_sq = {31'b0, mag} * {31'b0, mag};
      stop_at = {33'b0, thr} << THR_SHIFT;
      term = 64'd1 << FRAC_BITS;
      sum = ONE_Q40;
      used = 0;
      res.limit_reached = 1'b0;
      for (n = 1; n <= MAX_TERMS + 1; n++) begin
         if (used >= MAX_TERMS) begin
            res.limit_reached = 1'b1;
            break;
         end
         d = 64'((2 * n - 1) * (2 * n));
         prod = {64'b0, term} * {64'b0, x_sq};
         term = (prod[119:56] + d / 2) / d;
         if (term <= stop_at)
            break;
         if (n % 2 == 1)
            sum = sum - longint'(term);
         else
            sum = sum + longint'(term);
         used++;
      end
      if (sum >= ONE_Q40)
         res.cosine = COS_ONE;
      else if (sum <= -ONE_Q40)
         res.cosine = COS_MINUS_ONE;
      else
         res.cosine = 32'((sum + 512) >>> THR_SHIFT);
      res.terms_used = 5'(used);
      return res;
   endfunction

   function automatic int idle_length();
      if ($urandom_range(0, 99) < 80)
         return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic logic signed [ANGLE_W-1:0] random_angle();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6)
         return $urandom;
      if (pick < 8)
         return $urandom_range(0, 32'h2000_0000) - 32'sh1000_0000;
      if (pick == 8) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0;
            default: return -32'sh1;
         endcase
      end
      return $urandom_range(0, 511) - 256;
   endfunction

   // sender: one transaction at a time from angle_q
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         thr_model = 31'd1;
      end else begin
         if (csr_valid && csr_ready)
            thr_model = csr_accuracy_threshold;
         if (req_valid && !req_stall) begin
            cosine_q.push_back(cosine_series(req_angle, thr_model));
            accepted_total++;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left--;
            end else if (angle_q.size() > 0) begin
               req_valid <= 1'b1;
               req_angle <= angle_q.pop_front();
               gap_left = (no_idle || $urandom_range(0, 99) < 50) ? 0 : idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each result transaction against the oldest prediction
   always @(posedge clock) begin : result_check
      cos_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cosine_q.size() == 0) begin
               $error("result with no pending transaction: cosine %0d", rsp_cosine);
               fail_count++;
            end else begin
               want = cosine_q.pop_front();
               if (rsp_cosine !== want.cosine) begin
                  $error("cosine: expected %0d, actual %0d", want.cosine, rsp_cosine);
                  fail_count++;
               end
               if (rsp_terms_used !== want.terms_used) begin
                  $error("terms_used: expected %0d, actual %0d",
                         want.terms_used, rsp_terms_used);
                  fail_count++;
               end
               if (rsp_limit_reached !== want.limit_reached) begin
                  $error("limit_reached: expected %0d, actual %0d",
                         want.limit_reached, rsp_limit_reached);
                  fail_count++;
               end
            end
         end
         if (stall_left == 0 && !no_idle && $urandom_range(0, 99) < 30)
            stall_left = idle_length();
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push_angle(input logic signed [ANGLE_W-1:0] a);
      angle_q.push_back(a);
      queued_total++;
   endtask

   task automatic wait_drained();
      while (accepted_total != queued_total || cosine_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_accuracy_threshold <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   initial begin
      logic [THR_W-1:0] thr_plan [8];
      int               phase;
      thr_plan[0] = 31'd0;
      thr_plan[1] = 31'd1;
      thr_plan[2] = THR_W'($urandom_range(2, 1 << 20));
      thr_plan[3] = THR_UNITY;
      thr_plan[4] = THR_W'($urandom & {1'b0, THR_MAX});
      thr_plan[5] = THR_MAX;
      thr_plan[6] = 31'd1 << THR_SHIFT;
      thr_plan[7] = 31'd1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed angles at the reset threshold
      push_angle(32'sh0);
      push_angle(32'sh1);
      push_angle(-32'sh1);
      push_angle(32'sh7FFF_FFFF);
      push_angle(32'sh8000_0000);
      push_angle(32'sh1000_0000);
      push_angle(-32'sh1000_0000);
      push_angle(32'sh1921_FB54);
      push_angle(32'sh3243_F6A9);
      push_angle(-32'sh3243_F6A9);
      push_angle(32'sh6487_ED51);
      push_angle(32'sh0000_0100);
      push_angle(32'sh5555_5555);
      push_angle(32'shAAAA_AAAA);
      wait_drained();

      // zero threshold: longest series
      write_threshold(31'd0);
      push_angle(32'sh7FFF_FFFF);
      push_angle(32'sh8000_0000);
      push_angle(32'sh0);
      push_angle(32'sh4000_0000);
      wait_drained();

      // thresholds of one and just under two: small angles stop before the first term
      write_threshold(THR_UNITY);
      push_angle(32'sh7FFF_FFFF);
      push_angle(32'sh1000_0000);
      wait_drained();
      write_threshold(THR_MAX);
      push_angle(32'sh8000_0000);
      push_angle(32'sh0);
      wait_drained();

      for (phase = 0; phase < 8; phase++) begin
         write_threshold(thr_plan[phase]);
         no_idle = (phase == 2 || phase == 6);
         repeat (125) push_angle(random_angle());
         wait_drained();
      end
      no_idle = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && cosine_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #12_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
